// ----- rtl/core/lfps_pkg.sv -----
// Shared types and constants for the line-follow PID steering block.
// No dependencies.
package lfps_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CENTER    = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_DEAD_END  = 2'd2;
    localparam logic [1:0] REG_BRANCH    = 2'd3;

    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic [11:0] CENTER_RST    = 12'd2000;
    localparam logic [7:0]  MAX_SPEED_RST = 8'd60;
    localparam logic [9:0]  DEAD_END_RST  = 10'd100;
    localparam logic [9:0]  BRANCH_RST    = 10'd200;

    // |err| / 20 as (|err| * 3277) >> 16, exact for |err| < 4096
    localparam logic [11:0] ERR_DIV_MUL   = 12'd3277;
    localparam int          ERR_DIV_SHIFT = 16;

    // |sum| / 10000 as (|sum| * R) >> 42, exact for |sum| < 2^28.
    // Larger sums are clipped: the quotient then swamps any other term and
    // the steering clamps the same way.
    localparam int          SDIV_IN_W  = 28;
    localparam logic [27:0] SDIV_IN_MAX = '1;
    localparam int          SDIV_MUL_W = 29;
    localparam logic [28:0] SDIV_MUL   = 29'd439804652;
    localparam int          SDIV_SHIFT = 42;

    typedef enum logic [1:0] {
        EV_FOLLOW   = 2'd0,
        EV_DEAD_END = 2'd1,
        EV_BRANCH   = 2'd2
    } track_event_t;

endpackage

// ----- rtl/core/line_follow_pid_steering.sv -----
// Top level of the line-follow PID steering block: error, integral and
// derivative update, track event detection, constant divisions, clamp and motor split.
// Depends on lfps_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one line-sensor reading per
//   transaction. Output channel (out_valid / out_stall): one set of motor
//   drives and a track event per input, in order.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index;
//   write only while no reading is in flight.
//   Pipeline: the input stage loads at the accepting edge, then the multiply
//   stage, then the output register, which raises out_valid.
//   Throughput: one reading per cycle while in_stall is low. The error sum
//   and previous error are updated in the cycle a reading is taken, so
//   readings can follow back to back; the two constant divisions are
//   reciprocal multiplies in the second stage.
//   Stall: a stalled output holds its result; the stages behind it keep
//   filling, and in_stall rises only when all three stages hold a result.
//   Reset: registers return to their defaults (center 2000, max speed 60,
//   dead-end level 100, branch level 200), state and pipeline are cleared.
module line_follow_pid_steering
    import lfps_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [11:0]           line_position,
    input  logic [9:0]            level_far_left,
    input  logic [9:0]            level_left,
    input  logic [9:0]            level_middle,
    input  logic [9:0]            level_right,
    input  logic [9:0]            level_far_right,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            drive_left,
    output logic [7:0]            drive_right,
    output logic [1:0]            track_event
);

    localparam int MAGX_W = (SUM_WIDTH > SDIV_IN_W) ? SUM_WIDTH : SDIV_IN_W;
    localparam int SPROD_W = SDIV_IN_W + SDIV_MUL_W;

    // Configuration
    logic [11:0] center_reg;
    logic [7:0]  max_speed_reg;
    logic [9:0]  dead_end_reg;
    logic [9:0]  branch_reg;

    // Loop state
    logic signed [12:0]          prev_err_reg;
    logic signed [SUM_WIDTH-1:0] err_sum_reg;

    // Pipeline control
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_ready, s2_ready, s1_ready, accept;

    // Stage 1 payload
    logic signed [12:0]          s1_err_reg;
    logic signed [13:0]          s1_deriv_reg;
    logic signed [SUM_WIDTH-1:0] s1_sum_reg;
    track_event_t                s1_ev_reg;

    // Stage 2 payload
    logic [23:0]         s2_eprod_reg;
    logic                s2_eneg_reg;
    logic [SPROD_W-1:0]  s2_sprod_reg;
    logic                s2_sneg_reg;
    logic signed [14:0]  s2_dterm_reg;
    track_event_t        s2_ev_reg;

    // Output register
    logic [7:0]   drive_left_reg;
    logic [7:0]   drive_right_reg;
    track_event_t ev_out_reg;

    // ---------------- stage 0: input, state update, event
    logic signed [12:0]          err;
    logic signed [13:0]          deriv;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic                        dead_end, branch;
    track_event_t                ev;

    assign out_ready = !out_v_reg || !out_stall;
    assign s2_ready  = !s2_v_reg || out_ready;
    assign s1_ready  = !s1_v_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && s1_ready;

    always_comb
    begin
        err      = $signed({1'b0, line_position}) - $signed({1'b0, center_reg});
        deriv    = 14'(err) - 14'(prev_err_reg);
        sum_wide = (SUM_WIDTH+1)'(err_sum_reg) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
        begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
        dead_end = (level_left < dead_end_reg) && (level_middle < dead_end_reg)
                   && (level_right < dead_end_reg);
        branch   = (level_far_left > branch_reg) || (level_far_right > branch_reg);
        priority if (dead_end)
            ev = EV_DEAD_END;
        else if (branch)
            ev = EV_BRANCH;
        else
            ev = EV_FOLLOW;
    end

    // ---------------- stage 1: magnitudes and reciprocal multiplies
    logic [11:0]          err_mag;
    logic [SUM_WIDTH-1:0] sum_mag;
    logic [MAGX_W-1:0]    sum_magx;
    logic [SDIV_IN_W-1:0] sum_clip;
    logic signed [15:0]   d3;
    logic signed [15:0]   d3_half;
    logic [23:0]          eprod_next;
    logic [SPROD_W-1:0]   sprod_next;

    always_comb
    begin
        err_mag    = s1_err_reg[12] ? 12'(-s1_err_reg) : 12'(s1_err_reg);
        sum_mag    = s1_sum_reg[SUM_WIDTH-1] ? SUM_WIDTH'(-s1_sum_reg)
                                             : SUM_WIDTH'(s1_sum_reg);
        sum_magx   = MAGX_W'(sum_mag);
        sum_clip   = (sum_magx > MAGX_W'(SDIV_IN_MAX)) ? SDIV_IN_MAX
                                                       : sum_magx[SDIV_IN_W-1:0];
        eprod_next = 24'(err_mag) * 24'(ERR_DIV_MUL);
        sprod_next = SPROD_W'(sum_clip) * SPROD_W'(SDIV_MUL);
        // truncating halve: round negatives up
        d3         = 16'(s1_deriv_reg) * 16'sd3;
        d3_half    = d3[15] ? ((d3 + 16'sd1) >>> 1) : (d3 >>> 1);
    end

    // ---------------- stage 2: quotients, steering sum, clamp, split
    logic [7:0]         eq;
    logic [14:0]        sq;
    logic signed [16:0] steer;
    logic signed [16:0] lim;
    logic signed [16:0] steer_c;
    logic [7:0]         dl_next, dr_next;

    always_comb
    begin
        eq      = s2_eprod_reg[ERR_DIV_SHIFT +: 8];
        sq      = s2_sprod_reg[SDIV_SHIFT +: 15];
        steer   = (s2_eneg_reg ? -17'(eq) : 17'(eq))
                + (s2_sneg_reg ? -17'(sq) : 17'(sq))
                + 17'(s2_dterm_reg);
        lim     = 17'(max_speed_reg);
        priority if (steer > lim)
            steer_c = lim;
        else if (steer < -lim)
            steer_c = -lim;
        else
            steer_c = steer;
        if (steer_c < 0)
        begin
            dl_next = max_speed_reg + steer_c[7:0];
            dr_next = max_speed_reg;
        end
        else
        begin
            dl_next = max_speed_reg;
            dr_next = max_speed_reg - steer_c[7:0];
        end
    end

    // ---------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= CENTER_RST;
            max_speed_reg <= MAX_SPEED_RST;
            dead_end_reg  <= DEAD_END_RST;
            branch_reg    <= BRANCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER:    center_reg    <= cfg_wdata[11:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_wdata[7:0];
                REG_DEAD_END:  dead_end_reg  <= cfg_wdata[9:0];
                REG_BRANCH:    branch_reg    <= cfg_wdata[9:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                // an event ends the run: integral and history restart
                prev_err_reg <= (ev != EV_FOLLOW) ? '0 : err;
                err_sum_reg  <= (ev != EV_FOLLOW) ? '0 : sum_sat;
            end
            if (s1_ready)
                s1_v_reg <= in_valid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
            if (out_ready)
                out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_err_reg   <= err;
            s1_deriv_reg <= deriv;
            s1_sum_reg   <= sum_sat;
            s1_ev_reg    <= ev;
        end
        if (s2_ready)
        begin
            s2_eprod_reg <= eprod_next;
            s2_eneg_reg  <= s1_err_reg[12];
            s2_sprod_reg <= sprod_next;
            s2_sneg_reg  <= s1_sum_reg[SUM_WIDTH-1];
            s2_dterm_reg <= d3_half[14:0];
            s2_ev_reg    <= s1_ev_reg;
        end
        if (out_ready)
        begin
            drive_left_reg  <= dl_next;
            drive_right_reg <= dr_next;
            ev_out_reg      <= s2_ev_reg;
        end
    end

    assign out_valid   = out_v_reg;
    assign drive_left  = drive_left_reg;
    assign drive_right = drive_right_reg;
    assign track_event = ev_out_reg;

`ifndef SYNTHESIS
    a_event_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ev != EV_FOLLOW) |=> (err_sum_reg == '0 && prev_err_reg == '0))
        else $error("loop state not cleared after track event");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_v_reg && s2_v_reg && out_v_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_out_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(s2_v_reg))
        else $error("result appeared without a stage 2 transaction");
`endif

endmodule
